// ----- rtl/core/atcl_pkg.sv -----
// Package for the AT command line recognizer: status codes, sequencer states,
// command name table and default sizes. No dependencies.
`default_nettype none
package atcl_pkg;

  localparam int LINE_DEPTH_DEF = 64;
  localparam int NAME_MAX_DEF   = 10;

  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_EQ   = 8'h3D;

  localparam int NUM_NAMES  = 8;
  localparam int NAME_COLS  = 16;
  localparam int COL_W      = $clog2(NAME_COLS);
  localparam int NAME_LEN_W = $clog2(NAME_COLS + 1);

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FAIL    = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_MATCH   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } state_t;

  // Names are left-justified: character j sits at the top of the word minus 8*j.
  localparam logic [NAME_COLS*8-1:0] NAME_TEXT [NUM_NAMES] = '{
    {"Test",       96'd0},
    {"Init",       96'd0},
    {"DrawHeart",  56'd0},
    {"SetTime",    72'd0},
    {"DrawHours",  56'd0},
    {"DrawString", 48'd0},
    {"DrawName",   64'd0},
    {"DrawDate",   64'd0}
  };

  localparam logic [NAME_LEN_W-1:0] NAME_LEN [NUM_NAMES] = '{
    NAME_LEN_W'(4), NAME_LEN_W'(4), NAME_LEN_W'(9), NAME_LEN_W'(7),
    NAME_LEN_W'(9), NAME_LEN_W'(10), NAME_LEN_W'(8), NAME_LEN_W'(8)
  };

  function automatic logic [7:0] name_char(input int k, input logic [COL_W-1:0] j);
    name_char = NAME_TEXT[k][8*(NAME_COLS-1-int'(j)) +: 8];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/at_command_line_recognizer.sv -----
// Top level of the AT command line recognizer: line buffer RAM and the
// sequencer that checks a line at carriage return. Uses atcl_pkg, atcl_ram.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid, in_ready, in_rx_byte         | sink
//   out     | out_valid, out_ready, out_status,      | source
//           | out_cmd_idx                            |
//
// A byte other than carriage return is one RAM write while the buffer has room.
// A carriage return walks the buffer one byte a cycle from the RAM read port
// through the AT+ prefix and at most NAME_MAX name characters, then resolves
// the match in a final state; in_ready is low until the sequencer is idle again.
// The result sits in an output register; a stalled result holds the resolve
// cycle only if a second line ends first. Reset empties the line (fill count).
`default_nettype none
module at_command_line_recognizer #(
  parameter int LINE_DEPTH = atcl_pkg::LINE_DEPTH_DEF,
  parameter int NAME_MAX   = atcl_pkg::NAME_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [2:0]      out_cmd_idx
);
  import atcl_pkg::*;

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int FW = $clog2(LINE_DEPTH + 1);
  localparam int LW = $clog2(NAME_MAX + 1);

  state_t               state_r, state_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [FW-1:0]        pos_r, pos_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [NUM_NAMES-1:0] cand_r, cand_nxt;
  logic                 named_r, named_nxt;
  status_t              status_r, status_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [2:0]           res_idx_r, res_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [7:0]           ram_rdata;
  logic                 in_xfer;
  logic                 is_cr;
  logic [7:0]           cur_char;
  logic [LW-1:0]        len_inc;
  logic [NUM_NAMES-1:0] char_eq;
  logic [NUM_NAMES-1:0] hit;
  logic                 scan_end;

  atcl_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[AW-1:0]),
    .wdata (in_rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready    = (state_r == ST_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign is_cr       = (in_rx_byte == CHAR_CR);
  assign ram_we      = in_xfer && !is_cr && (fill_r < FW'(LINE_DEPTH));
  assign out_valid   = out_valid_r;
  assign out_status  = res_status_r;
  assign out_cmd_idx = res_idx_r;

  // Positions past the stored bytes read as zero.
  assign cur_char = (pos_r < fill_r) ? ram_rdata : 8'd0;
  assign len_inc  = len_r + LW'(1);

  always_comb begin
    for (int k = 0; k < NUM_NAMES; k++) begin
      char_eq[k] = (name_char(k, len_r[COL_W-1:0]) == cur_char);
      hit[k]     = cand_r[k] && (NAME_LEN[k] == NAME_LEN_W'(len_r));
    end
  end

  // Scan ends at a mismatch in the AT+ prefix, or where the name ends: at '=', a zero byte or after NAME_MAX characters
  always_comb begin
    scan_end = 1'b0;
    if (pos_r == FW'(0)) begin
      scan_end = (cur_char != CHAR_A);
    end else if (pos_r == FW'(1)) begin
      scan_end = (cur_char != CHAR_T);
    end else if (pos_r == FW'(2)) begin
      scan_end = (cur_char != CHAR_PLUS);
    end else begin
      scan_end = (cur_char == CHAR_EQ) || (cur_char == 8'd0) ||
                 (len_inc == LW'(NAME_MAX));
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_cr) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    len_nxt        = len_r;
    cand_nxt       = cand_r;
    named_nxt      = named_r;
    status_nxt     = status_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    ram_raddr      = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (is_cr) begin
            pos_nxt   = '0;
            len_nxt   = '0;
            cand_nxt  = '1;
            named_nxt = 1'b0;
          end else if (ram_we) begin
            fill_nxt = fill_r + FW'(1);
          end
        end
      end
      ST_SCAN: begin
        ram_raddr = AW'(pos_r + FW'(1));
        pos_nxt   = pos_r + FW'(1);
        if (pos_r == FW'(0) || pos_r == FW'(1)) begin
          status_nxt = STAT_FAIL;
        end else if (pos_r == FW'(2)) begin
          status_nxt = STAT_OK;
        end else begin
          named_nxt = 1'b1;
          if (cur_char != CHAR_EQ && cur_char != 8'd0) begin
            cand_nxt = cand_r & char_eq;
            len_nxt  = len_inc;
          end
        end
      end
      ST_FINAL: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          fill_nxt       = '0;
          res_idx_nxt    = '0;
          res_status_nxt = status_r;
          if (named_r) begin
            res_status_nxt = STAT_UNKNOWN;
            if (len_r != '0) begin
              for (int k = NUM_NAMES - 1; k >= 0; k--) begin
                if (hit[k]) begin
                  res_status_nxt = STAT_MATCH;
                  res_idx_nxt    = 3'(k);
                end
              end
            end
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    len_r        <= len_nxt;
    cand_r       <= cand_nxt;
    named_r      <= named_nxt;
    status_r     <= status_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/core/atcl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module atcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- test/at_command_line_recognizer_tb.sv -----
// Self-checking testbench for at_command_line_recognizer: drives random and directed
// AT command lines byte by byte and checks each line verdict against a built-in predictor.
// Depends on atcl_pkg and the RTL of the block only.
`default_nettype none
module at_command_line_recognizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atcl_pkg::*;

  localparam int LINE_BYTES  = LINE_DEPTH_DEF;
  localparam int NAME_LIMIT  = NAME_MAX_DEF;
  localparam int ITEM_TARGET = 1300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 20;

  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    status_t    status;
    logic [2:0] index;
  } line_verdict_t;

  // Keeps its own copy of the line buffer, predicts the verdict of each line
  // at carriage return and checks the block's results in order.
  class line_scoreboard;
    logic [7:0]    line_buf [LINE_BYTES];
    int unsigned   fill;
    line_verdict_t verdict_q [$];
    int unsigned   errors;
    string         names [8];

    function new();
      names = '{"Test", "Init", "DrawHeart", "SetTime", "DrawHours", "DrawString",
                "DrawName", "DrawDate"};
      fill = 0;
      errors = 0;
      foreach (line_buf[i]) line_buf[i] = 8'h00;
    endfunction

    function logic [7:0] byte_at(int unsigned pos);
      return (pos < fill) ? line_buf[pos] : 8'h00;
    endfunction

    function line_verdict_t judge_line();
      line_verdict_t v;
      int            len;
      logic [7:0]    c;
      bit            same;
      v.status = STAT_FAIL;
      v.index = 3'd0;
      if (byte_at(0) != CHAR_A || byte_at(1) != CHAR_T) return v;
      v.status = STAT_OK;
      if (byte_at(2) != CHAR_PLUS) return v;
      v.status = STAT_UNKNOWN;
      len = 0;
      while (len < NAME_LIMIT) begin
        c = byte_at(3 + len);
        if (c == CHAR_EQ || c == 8'h00) break;
        len++;
      end
      if (len == 0) return v;
      for (int k = 0; k < 8; k++) begin
        if (names[k].len() == len) begin
          same = 1'b1;
          for (int j = 0; j < len; j++)
            if (names[k][j] != byte_at(3 + j)) same = 1'b0;
          if (same) begin
            v.status = STAT_MATCH;
            v.index = 3'(k);
            return v;
          end
        end
      end
      return v;
    endfunction

    function void note_byte(logic [7:0] b);
      if (b == CHAR_CR) begin
        verdict_q.push_back(judge_line());
        foreach (line_buf[i]) line_buf[i] = 8'h00;
        fill = 0;
      end else if (fill < LINE_BYTES) begin
        line_buf[fill] = b;
        fill++;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [2:0] idx);
      line_verdict_t v;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result: status %0d index %0d", $time, st, idx);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (st !== v.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d", $time, v.status, st);
        errors++;
      end
      if (idx !== v.index) begin
        $display("%0t: cmd_idx mismatch: expected %0d actual %0d", $time, v.index, idx);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic [2:0] out_cmd_idx;

  line_scoreboard sb = new();
  int unsigned    bytes_sent = 0;
  int unsigned    cycle_count = 0;
  bit             no_idle = 1'b0;
  bit             hold_req = 1'b0;

  at_command_line_recognizer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_cmd_idx(out_cmd_idx)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("at_command_line_recognizer_tb: FAIL");
      $finish;
    end
  end

  function automatic void append_text(ref byte_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] text_char();
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  // One random line, carriage return included. About a third are well-formed commands.
  function automatic byte_q_t make_line();
    byte_q_t q;
    int      pick;
    int      k;
    int      n;
    int      pos;
    pick = $urandom_range(99);
    k = $urandom_range(7);
    if (pick < 35) begin
      append_text(q, "AT+");
      append_text(q, sb.names[k]);
      if ($urandom_range(1)) begin
        q.push_back(CHAR_EQ);
        n = $urandom_range(6);
        repeat (n) q.push_back(text_char());
      end
    end else if (pick < 45) begin
      // near miss: one character changed, dropped or added
      append_text(q, "AT+");
      append_text(q, sb.names[k]);
      case ($urandom_range(2))
        0: begin
          pos = $urandom_range(3, q.size() - 1);
          q[pos] = 8'($urandom_range(8'h41, 8'h7a));
        end
        1: void'(q.pop_back());
        default: q.push_back(8'($urandom_range(8'h41, 8'h7a)));
      endcase
    end else if (pick < 50) begin
      // name with extra letters, longer than the name limit when it starts from DrawString
      append_text(q, "AT+");
      append_text(q, sb.names[$urandom_range(1) ? 5 : k]);
      n = $urandom_range(1, 5);
      repeat (n) q.push_back(8'($urandom_range(8'h41, 8'h7a)));
    end else if (pick < 58) begin
      append_text(q, "AT");
      n = $urandom_range(5);
      repeat (n) q.push_back(text_char());
      if (q.size() > 2 && q[2] == CHAR_PLUS) q[2] = 8'h78;
    end else if (pick < 63) begin
      append_text(q, "AT+");
      if ($urandom_range(1)) q.push_back(CHAR_EQ);
      n = $urandom_range(3);
      repeat (n) q.push_back(text_char());
    end else if (pick < 71) begin
      append_text(q, "AT+");
      append_text(q, sb.names[k]);
      pos = $urandom_range(q.size());
      q.insert(pos, 8'h00);
    end else if (pick < 77) begin
      // long line that can overflow the line buffer
      append_text(q, "AT+");
      append_text(q, sb.names[k]);
      q.push_back(CHAR_EQ);
      n = $urandom_range(62, 90);
      while (q.size() < n) q.push_back(text_char());
    end else if (pick < 85) begin
      n = $urandom_range(1, 10);
      repeat (n) q.push_back(text_char());
    end else begin
      n = $urandom_range(15);
      repeat (n) q.push_back(8'($urandom_range(255)));
    end
    q.push_back(CHAR_CR);
    return q;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!no_idle && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line(input byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    byte_q_t line;
    int      line_no;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: plain AT, extreme bytes without prefix, empty names, one match
    line = {};
    append_text(line, "AT");
    line.push_back(CHAR_CR);
    send_line(line);
    line = '{8'hFF, 8'h00, CHAR_CR};
    send_line(line);
    line = {};
    append_text(line, "AT+");
    line.push_back(CHAR_CR);
    send_line(line);
    line = {};
    append_text(line, "AT+=");
    line.push_back(CHAR_CR);
    send_line(line);
    line = {};
    append_text(line, "AT+Test");
    line.push_back(CHAR_CR);
    send_line(line);

    line_no = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (line_no == 15) hold_req = 1'b1;
      if (line_no == 40) wait_all_results();
      no_idle = (line_no >= 60 && line_no < 80);
      send_line(make_line());
      line_no++;
    end
    no_idle = 1'b0;

    wait_all_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("at_command_line_recognizer_tb: PASS");
    else
      $display("at_command_line_recognizer_tb: FAIL");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_status, out_cmd_idx);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 30);
      end
    end
  end

endmodule
`default_nettype wire
